/* hw/rtl/gle_pkg.sv */
// Shared types and constants for the GIF LZW encoder.
package gle_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = 5;
    localparam int RB_MIN   = 2;
    localparam int RB_MAX   = 8;
    localparam int RB_RESET = 8;

    // Which code the datapath presents to the packer
    typedef enum logic [1:0] {
        CODE_PREFIX,
        CODE_CLEAR,
        CODE_END
    } t_code_sel;

    // Commands from the controller to the table datapath
    typedef struct packed {
        logic      capture;
        logic      init;
        logic      set_img;
        logic      drop_img;
        logic      head_rd;
        logic      head_chk;
        logic      node_rd;
        logic      node_from_sib;
        logic      node_miss;
        logic      found;
        logic      insert;
        logic      prefix_pix;
        t_code_sel code_sel;
    } t_dp_cmd;

    // Status from the table datapath
    typedef struct packed {
        logic img;
        logic last;
        logic head_in_range;
        logic node_hit;
        logic node_prefix_eq;
        logic sib_nz;
        logic full;
    } t_dp_sts;

    // Commands from the controller to the bit packer
    typedef struct packed {
        logic put;
        logic flush;
        logic eoi;
    } t_pk_cmd;

endpackage

/* hw/rtl/gle_dp.sv */
// String table datapath: config, image state, head and node memories, search pointer.
module gle_dp
    import gle_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_W-1:0]         i_cfg_wr_data,
    input  logic [BYTE_W-1:0]        i_pixel,
    input  logic                     i_last_pixel,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic [MAX_CODE_BITS-1:0] o_code,
    output logic [3:0]               o_width
);

    localparam int W     = MAX_CODE_BITS;
    localparam int TSIZE = 1 << W;
    localparam int NW    = W + BYTE_W + W;

    logic [CFG_W-1:0]  r_cfg;
    logic [3:0]        r_rb;
    logic [W:0]        r_next;
    logic [3:0]        r_width;
    logic [W-1:0]      r_prefix;
    logic [BYTE_W-1:0] r_raw;
    logic              r_last;
    logic              r_img;
    logic              r_head_ok;
    logic [W-1:0]      r_head_q;
    logic [NW-1:0]     r_node_q;
    logic [W-1:0]      r_node_addr_q;

    logic [W-1:0]      mem_head [TSIZE];
    logic [NW-1:0]     mem_node [TSIZE];

    logic [3:0]        n_rb;
    logic [BYTE_W-1:0] pix_c;
    logic [W-1:0]      clear_code;
    logic [W-1:0]      node_prefix;
    logic [BYTE_W-1:0] node_char;
    logic [W-1:0]      node_sib;
    logic [W-1:0]      node_addr;
    logic              ins_wr;
    logic              grow;

    // Clamp the root size from the register
    always_comb begin
        if (r_cfg < CFG_W'(RB_MIN)) begin
            n_rb = 4'(RB_MIN);
        end else if (r_cfg > CFG_W'(RB_MAX)) begin
            n_rb = 4'(RB_MAX);
        end else begin
            n_rb = r_cfg;
        end
    end

    assign pix_c       = r_raw & BYTE_W'((9'd1 << r_rb) - 9'd1);
    assign clear_code  = W'(1) << r_rb;
    assign node_prefix = r_node_q[NW-1 -: W];
    assign node_char   = r_node_q[W +: BYTE_W];
    assign node_sib    = r_node_q[W-1:0];
    assign node_addr   = i_cmd.node_from_sib ? node_sib : r_head_q;
    assign ins_wr      = i_cmd.insert && !r_next[W];
    assign grow        = (r_next >= ((W+1)'(1) << r_width)) && (r_width < 4'(W));

    // Status towards the controller
    always_comb begin
        o_sts.img            = r_img;
        o_sts.last           = r_last;
        o_sts.head_in_range  = ({1'b0, r_head_q} >= ({1'b0, clear_code} + (W+1)'(2)))
                               && ({1'b0, r_head_q} < r_next);
        o_sts.node_prefix_eq = node_prefix == r_prefix;
        o_sts.node_hit       = (node_prefix == r_prefix) && (node_char == pix_c);
        o_sts.sib_nz         = node_sib != '0;
        o_sts.full           = r_next[W];
    end

    // Select the code for the packer
    always_comb begin
        case (i_cmd.code_sel)
            CODE_CLEAR: o_code = clear_code;
            CODE_END:   o_code = clear_code + W'(1);
            default:    o_code = r_prefix;
        endcase
    end
    assign o_width = r_width;

    // Control state of the image and the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_W'(RB_RESET);
            r_rb    <= 4'(RB_RESET);
            r_next  <= (W+1)'((1 << RB_RESET) + 2);
            r_width <= 4'(RB_RESET + 1);
            r_img   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.init) begin
                r_rb    <= n_rb;
                r_next  <= (W+1)'((W+1)'(1) << n_rb) + (W+1)'(2);
                r_width <= n_rb + 4'd1;
            end else if (i_cmd.insert) begin
                if (r_next[W]) begin
                    // full table: start over
                    r_next  <= {1'b0, clear_code} + (W+1)'(2);
                    r_width <= r_rb + 4'd1;
                end else begin
                    r_next <= r_next + (W+1)'(1);
                    if (grow) begin
                        r_width <= r_width + 4'd1;
                    end
                end
            end
            if (i_cmd.set_img) begin
                r_img <= 1'b1;
            end else if (i_cmd.drop_img) begin
                r_img <= 1'b0;
            end
        end
    end

    // Word, prefix and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw  <= i_pixel;
            r_last <= i_last_pixel;
        end
        if (i_cmd.found) begin
            r_prefix <= r_node_addr_q;
        end else if (i_cmd.prefix_pix) begin
            r_prefix <= W'(pix_c);
        end
        if (i_cmd.head_chk) begin
            r_head_ok <= o_sts.head_in_range;
        end else if (i_cmd.node_miss) begin
            r_head_ok <= r_head_ok && o_sts.node_prefix_eq;
        end
    end

    // Head memory: first child of each code
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) begin
            r_head_q <= mem_head[r_prefix];
        end
        if (ins_wr) begin
            mem_head[r_prefix] <= r_next[W-1:0];
        end
    end

    // Node memory: prefix, pixel and next sibling of each code
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_rd) begin
            r_node_q      <= mem_node[node_addr];
            r_node_addr_q <= node_addr;
        end
        if (ins_wr) begin
            mem_node[r_next[W-1:0]] <= {r_prefix, pix_c, r_head_ok ? r_head_q : W'(0)};
        end
    end

endmodule

/* hw/rtl/gle_packer.sv */
// Bit packer: LSB-first code accumulator, held-back byte and output register.
module gle_packer
    import gle_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pk_cmd                  i_cmd,
    input  logic [MAX_CODE_BITS-1:0] i_code,
    input  logic [3:0]               i_width,
    output logic                     o_busy,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [BYTE_W-1:0]        o_code_byte,
    output logic                     o_last_of_run,
    output logic                     o_end_of_image
);

    localparam int W  = MAX_CODE_BITS;
    localparam int AW = W + 7;

    logic [AW-1:0]     r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_flush;
    logic              r_eoi;
    logic              r_pv;
    logic [BYTE_W-1:0] r_pend;
    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_olast;
    logic              r_oeoi;

    logic              out_free;
    logic              have_byte;
    logic              full_byte;
    logic [W-1:0]      code_m;
    logic              push_mid;
    logic              push_end;

    assign out_free  = !r_ov || i_ready;
    assign full_byte = r_cnt >= CNT_W'(8);
    assign have_byte = full_byte || (r_flush && r_eoi && (r_cnt != '0));
    assign code_m    = i_code & W'(((W+1)'(1) << i_width) - (W+1)'(1));
    assign o_busy    = full_byte || r_flush;

    // Move the held byte out: mid-item when a newer byte replaces it, or as the item's last
    assign push_mid  = !i_cmd.put && have_byte && r_pv && out_free;
    assign push_end  = !i_cmd.put && !have_byte && r_flush && r_pv && out_free;

    assign o_valid        = r_ov;
    assign o_code_byte    = r_ob;
    assign o_last_of_run  = r_olast;
    assign o_end_of_image = r_oeoi;

    // Accumulate codes, drain bytes through the held-back stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_flush <= 1'b0;
            r_eoi   <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_acc <= r_acc | (AW'(code_m) << r_cnt);
                r_cnt <= r_cnt + CNT_W'(i_width);
            end else if (have_byte) begin
                if (!r_pv || out_free) begin
                    r_pv   <= 1'b1;
                    r_pend <= r_acc[BYTE_W-1:0];
                    if (full_byte) begin
                        r_acc <= r_acc >> BYTE_W;
                        r_cnt <= r_cnt - CNT_W'(8);
                    end else begin
                        r_acc <= '0;
                        r_cnt <= '0;
                    end
                end
            end else if (r_flush) begin
                // close the item: the held byte is its last
                if (!r_pv) begin
                    r_flush <= 1'b0;
                end else if (out_free) begin
                    r_pv    <= 1'b0;
                    r_flush <= 1'b0;
                end
            end
            if (i_cmd.flush) begin
                r_flush <= 1'b1;
                r_eoi   <= i_cmd.eoi;
            end
            // Load the output register, or free it once taken
            if (push_mid || push_end) begin
                r_ov    <= 1'b1;
                r_ob    <= r_pend;
                r_olast <= push_end;
                r_oeoi  <= push_end && r_eoi;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_put_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put || i_cmd.flush) |-> !o_busy)
        else $error("packer command while busy");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.put && i_cmd.flush))
        else $error("put and flush together");
    a_eoi_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_flush) && r_eoi) |-> (r_cnt == '0))
        else $error("bits left after end of image");

endmodule

/* hw/rtl/gle_ctrl.sv */
// Controller: sequences search, insert, code emission and flush per pixel word.
module gle_ctrl
    import gle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    input  logic    i_pk_busy,
    output t_dp_cmd o_dp,
    output t_pk_cmd o_pk
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CLR0, S_HEAD, S_HCHK, S_NODE,
        S_MISS, S_INS, S_TAIL, S_LPRE, S_LEND, S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = r_state == S_IDLE;

    // Decode commands and the next state
    always_comb begin
        n_state  = r_state;
        o_dp     = '0;
        o_pk     = '0;
        o_dp.code_sel = CODE_PREFIX;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp.capture = 1'b1;
                    n_state = i_sts.img ? S_HEAD : S_INIT;
                end
            end
            S_INIT: begin
                o_dp.init = 1'b1;
                n_state = S_CLR0;
            end
            S_CLR0: begin
                o_dp.code_sel = CODE_CLEAR;
                if (!i_pk_busy) begin
                    o_pk.put = 1'b1;
                    o_dp.prefix_pix = 1'b1;
                    o_dp.set_img = 1'b1;
                    n_state = S_TAIL;
                end
            end
            S_HEAD: begin
                o_dp.head_rd = 1'b1;
                n_state = S_HCHK;
            end
            S_HCHK: begin
                o_dp.head_chk = 1'b1;
                if (i_sts.head_in_range) begin
                    o_dp.node_rd = 1'b1;
                    n_state = S_NODE;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_NODE: begin
                if (i_sts.node_hit) begin
                    o_dp.found = 1'b1;
                    n_state = S_TAIL;
                end else if (!i_sts.node_prefix_eq) begin
                    o_dp.node_miss = 1'b1;
                    n_state = S_MISS;
                end else if (i_sts.sib_nz) begin
                    o_dp.node_rd = 1'b1;
                    o_dp.node_from_sib = 1'b1;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (!i_pk_busy) begin
                    o_pk.put = 1'b1;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_dp.code_sel = CODE_CLEAR;
                if (!i_pk_busy) begin
                    o_pk.put = i_sts.full;
                    o_dp.insert = 1'b1;
                    o_dp.prefix_pix = 1'b1;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = i_sts.last ? S_LPRE : S_FLUSH;
            end
            S_LPRE: begin
                if (!i_pk_busy) begin
                    o_pk.put = 1'b1;
                    n_state = S_LEND;
                end
            end
            S_LEND: begin
                o_dp.code_sel = CODE_END;
                if (!i_pk_busy) begin
                    o_pk.put = 1'b1;
                    o_dp.drop_img = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_pk_busy) begin
                    o_pk.flush = 1'b1;
                    o_pk.eoi = i_sts.last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pk.put || o_pk.flush) |-> !i_pk_busy)
        else $error("packer command issued while busy");
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |=> (r_state == S_CLR0))
        else $error("init not followed by clear code");
    a_search_img: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |-> i_sts.img)
        else $error("search outside an image");

endmodule

/* hw/rtl/gif_lzw_encoder.sv */
// Top level of the GIF LZW encoder: controller, table datapath and bit packer.
//
//  port group     | direction | handshake           | payload
//  ---------------+-----------+---------------------+-------------------------------------
//  pixel in       | in        | i_valid / o_ready   | i_pixel, i_last_pixel
//  code bytes out | out       | o_valid / i_ready   | o_code_byte, o_last_of_run, o_end_of_image
//  config         | in        | i_cfg_wr_en         | i_cfg_wr_data (min_code_size)
//
// A pixel is taken only in the idle state. A hit at the head of the child chain passes
// S_HEAD, S_HCHK, S_NODE, S_TAIL and S_FLUSH; a miss adds S_MISS and S_INS before S_TAIL,
// without S_NODE if no valid chain; each further sibling adds a single-port node memory read.
// An image's first pixel goes S_INIT, S_CLR0, S_TAIL, S_FLUSH; the last adds prefix and end code.
// A put can leave up to two whole bytes, drained one per unstalled cycle before the next put.
// Reset is synchronous; no table clearing pass, stale links are rejected by range and
// prefix checks. A stalled output holds the packer and, through it, the controller.
module gif_lzw_encoder
    import gle_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_pixel,
    input  logic              i_last_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_code_byte,
    output logic              o_last_of_run,
    output logic              o_end_of_image
);

    t_dp_cmd                  dp_cmd;
    t_dp_sts                  dp_sts;
    t_pk_cmd                  pk_cmd;
    logic                     pk_busy;
    logic [MAX_CODE_BITS-1:0] code;
    logic [3:0]               width;

    gle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sts     (dp_sts),
        .i_pk_busy (pk_busy),
        .o_dp      (dp_cmd),
        .o_pk      (pk_cmd)
    );

    gle_dp #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel       (i_pixel),
        .i_last_pixel  (i_last_pixel),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_code        (code),
        .o_width       (width)
    );

    gle_packer #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (pk_cmd),
        .i_code         (code),
        .i_width        (width),
        .o_busy         (pk_busy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_byte    (o_code_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_image (o_end_of_image)
    );

endmodule
